@@ rtl/srt_pkg.sv @@
// Shared types and constants of the shortest-remaining-time scheduler.
package srt_pkg;

  localparam int unsigned ARR_W   = 16;
  localparam int unsigned BT_W    = 16;
  localparam int unsigned TIME_W  = 24;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ENTRY_W = ARR_W + 2 * BT_W;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic exec;
  } srt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } srt_status_t;

endpackage

@@ rtl/srt_if.sv @@
// Valid/ready channel interfaces for the scheduler's input and result transfers.
interface srt_in_if import srt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ARR_W-1:0]  arrival_time;
  logic [BT_W-1:0]   burst_time;

  modport source (output valid, operation, arrival_time, burst_time, input ready);
  modport sink   (input valid, operation, arrival_time, burst_time, output ready);
endinterface

interface srt_out_if import srt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic              status;
  logic              idle;
  logic              finished;
  logic [TIME_W-1:0] completion_time;
  logic [TIME_W-1:0] turnaround_time;
  logic [TIME_W-1:0] waiting_time;

  modport source (output valid, slot, status, idle, finished, completion_time,
                  turnaround_time, waiting_time, input ready);
  modport sink   (input valid, slot, status, idle, finished, completion_time,
                  turnaround_time, waiting_time, output ready);
endinterface

@@ rtl/srt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module srt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/srt_ctrl.sv @@
// Controller state machine: input handshake, slot scan sequencing and result issue.
module srt_ctrl import srt_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  srt_status_t     status,
  output srt_cmd_t        cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_op == OP_TICK) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_EXEC;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      ST_EXEC: begin
        if (status.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> status.out_free)
    else $error("result issued while the output register is still occupied");

  a_scan_ends_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && status.scan_done |=> (state_r == ST_EXEC))
    else $error("completed scan did not move on to the update");

endmodule

@@ rtl/srt_dp.sv @@
// Datapath: job table, scan comparator, clock, result arithmetic and output register.
module srt_dp import srt_pkg::*; #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  srt_cmd_t          cmd,
  output srt_status_t       status,
  input  logic [OP_W-1:0]   in_op,
  input  logic [ARR_W-1:0]  in_arr,
  input  logic [BT_W-1:0]   in_bt,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_status,
  output logic              out_idle,
  output logic              out_finished,
  output logic [TIME_W-1:0] out_completion,
  output logic [TIME_W-1:0] out_turnaround,
  output logic [TIME_W-1:0] out_waiting
);

  localparam int unsigned IDXW = $clog2(MAX_JOBS);
  localparam int unsigned CNTW = $clog2(MAX_JOBS + 1);

  // Captured item and clock.
  logic [OP_W-1:0]   op_r;
  logic [ARR_W-1:0]  arr_r;
  logic [BT_W-1:0]   bt_r;
  logic [TIME_W-1:0] clock_r;
  logic [TIME_W-1:0] clock_nxt;
  logic [TIME_W-1:0] clk_inc_r;
  logic [CNTW-1:0]   job_cnt_r;
  logic [CNTW-1:0]   job_cnt_nxt;

  // Scan state.
  logic [CNTW-1:0]   scan_cnt_r;
  logic              rd_vld_r;
  logic [IDXW-1:0]   cmp_idx_r;
  logic              found_r;
  logic [IDXW-1:0]   best_idx_r;
  logic [ARR_W-1:0]  best_arr_r;
  logic [BT_W-1:0]   best_bt_r;
  logic [BT_W-1:0]   best_rem_r;
  logic [ARR_W:0]    best_ab_r;

  // Table memory.
  logic              ram_we;
  logic [IDXW-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ARR_W-1:0]  rd_arr;
  logic [BT_W-1:0]   rd_bt;
  logic [BT_W-1:0]   rd_rem;
  logic              better;

  // Output register.
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [SLOT_W-1:0] slot_r;
  logic              status_r;
  logic              idle_r;
  logic              finished_r;
  logic [TIME_W-1:0] ct_r;
  logic [TIME_W-1:0] tat_r;
  logic [TIME_W-1:0] wt_r;
  logic [SLOT_W-1:0] slot_nxt;
  logic              status_nxt;
  logic              idle_nxt;
  logic              finished_nxt;
  logic [TIME_W-1:0] ct_nxt;
  logic [TIME_W-1:0] tat_nxt;
  logic [TIME_W-1:0] wt_nxt;

  logic [BT_W-1:0]   rem_dec;
  logic [TIME_W-1:0] arr_ext;
  logic [TIME_W-1:0] ab_ext;

  srt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_JOBS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_cnt_r[IDXW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_arr = ram_rdata[ENTRY_W-1 -: ARR_W];
  assign rd_bt  = ram_rdata[2*BT_W-1 -: BT_W];
  assign rd_rem = ram_rdata[BT_W-1:0];

  assign better = ({{(TIME_W-ARR_W){1'b0}}, rd_arr} <= clock_r) && (rd_rem != '0) &&
                  (!found_r || (rd_rem < best_rem_r));

  assign status.scan_done = (scan_cnt_r == job_cnt_r);
  assign status.out_free  = !out_valid_r || out_ready;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r     <= '0;
      job_cnt_r   <= '0;
      scan_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clock_r     <= clock_nxt;
      job_cnt_r   <= job_cnt_nxt;
      rd_vld_r    <= cmd.scan_rd;
      out_valid_r <= out_valid_nxt;
      if (cmd.capture) begin
        scan_cnt_r <= '0;
        found_r    <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          scan_cnt_r <= scan_cnt_r + CNTW'(1);
        end
        if (rd_vld_r && better) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_op;
      arr_r     <= in_arr;
      bt_r      <= in_bt;
      clk_inc_r <= (clock_r == TIME_MAX) ? clock_r : clock_r + TIME_W'(1);
    end
    cmp_idx_r <= scan_cnt_r[IDXW-1:0];
    if (rd_vld_r && better) begin
      best_idx_r <= cmp_idx_r;
      best_arr_r <= rd_arr;
      best_bt_r  <= rd_bt;
      best_rem_r <= rd_rem;
      best_ab_r  <= {1'b0, rd_arr} + {1'b0, rd_bt};
    end
    if (cmd.exec) begin
      slot_r     <= slot_nxt;
      status_r   <= status_nxt;
      idle_r     <= idle_nxt;
      finished_r <= finished_nxt;
      ct_r       <= ct_nxt;
      tat_r      <= tat_nxt;
      wt_r       <= wt_nxt;
    end
  end

  assign rem_dec = best_rem_r - BT_W'(1);
  assign arr_ext = {{(TIME_W-ARR_W){1'b0}}, best_arr_r};
  assign ab_ext  = {{(TIME_W-ARR_W-1){1'b0}}, best_ab_r};

  always_comb begin
    clock_nxt     = clock_r;
    job_cnt_nxt   = job_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = job_cnt_r[IDXW-1:0];
    ram_wdata     = {arr_r, bt_r, bt_r};
    slot_nxt      = '0;
    status_nxt    = 1'b0;
    idle_nxt      = 1'b0;
    finished_nxt  = 1'b0;
    ct_nxt        = '0;
    tat_nxt       = '0;
    wt_nxt        = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
      case (op_r)
        OP_LOAD: begin
          if (job_cnt_r < CNTW'(MAX_JOBS)) begin
            ram_we      = 1'b1;
            slot_nxt    = SLOT_W'(job_cnt_r[IDXW-1:0]);
            job_cnt_nxt = job_cnt_r + CNTW'(1);
          end else begin
            status_nxt = 1'b1;
          end
        end
        OP_TICK: begin
          clock_nxt = clk_inc_r;
          if (!found_r) begin
            idle_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_r;
            ram_wdata = {best_arr_r, best_bt_r, rem_dec};
            slot_nxt  = SLOT_W'(best_idx_r);
            if (rem_dec == '0) begin
              finished_nxt = 1'b1;
              ct_nxt       = clk_inc_r;
              tat_nxt      = (clk_inc_r >= arr_ext) ? clk_inc_r - arr_ext : '0;
              wt_nxt       = (clk_inc_r >= ab_ext) ? clk_inc_r - ab_ext : '0;
            end
          end
        end
        OP_CLEAR: begin
          clock_nxt   = '0;
          job_cnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot       = slot_r;
  assign out_status     = status_r;
  assign out_idle       = idle_r;
  assign out_finished   = finished_r;
  assign out_completion = ct_r;
  assign out_turnaround = tat_r;
  assign out_waiting    = wt_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_cnt_r <= CNTW'(MAX_JOBS))
    else $error("job count exceeds the table depth");

  a_best_runnable: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (best_rem_r != '0))
    else $error("selected job has no remaining time");

  a_finish_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && finished_r |-> !idle_r && !status_r && (ct_r >= tat_r) && (tat_r >= wt_r))
    else $error("finishing result carries inconsistent times or flags");

endmodule

@@ rtl/shortest_remaining_time_scheduler.sv @@
// Top level of the preemptive shortest-remaining-time scheduler.
//
//   Channel  Direction  Handshake     Contents
//   in_ch    sink       valid/ready   operation, arrival_time, burst_time
//   out_ch   source     valid/ready   slot, status, idle, finished, three times
//
// Load, clear and unused operations are captured, then applied in the update state once the
// output register is free. A tick first scans the table: the single table read port visits
// one loaded slot per cycle, feeding one comparator, before the chosen entry is updated.
// A new item is taken while the previous result still waits in the output register.
// Synchronous reset empties the table and zeroes the clock; no clearing pass is run.
module shortest_remaining_time_scheduler import srt_pkg::*; #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  srt_in_if.sink     in_ch,
  srt_out_if.source  out_ch
);

  srt_cmd_t    cmd;
  srt_status_t status;

  srt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  srt_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_op          (in_ch.operation),
    .in_arr         (in_ch.arrival_time),
    .in_bt          (in_ch.burst_time),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_slot       (out_ch.slot),
    .out_status     (out_ch.status),
    .out_idle       (out_ch.idle),
    .out_finished   (out_ch.finished),
    .out_completion (out_ch.completion_time),
    .out_turnaround (out_ch.turnaround_time),
    .out_waiting    (out_ch.waiting_time)
  );

endmodule

@@ tb/sv/tb_shortest_remaining_time_scheduler.sv @@
`timescale 1ns / 100ps
// Self-checking testbench that runs the scheduler against a behavioural job table and clock.
module tb_shortest_remaining_time_scheduler;
  import srt_pkg::*;

  localparam int unsigned JOB_SLOTS = 16;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = JOB_SLOTS + 24;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              status;
    logic              idle;
    logic              finished;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
  } sched_result_t;

  logic clk;
  logic rst_n;

  srt_in_if  in_ch ();
  srt_out_if out_ch ();

  shortest_remaining_time_scheduler #(
    .MAX_JOBS(JOB_SLOTS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [ARR_W-1:0]  job_arrival   [JOB_SLOTS];
  logic [BT_W-1:0]   job_burst     [JOB_SLOTS];
  logic [BT_W-1:0]   job_remaining [JOB_SLOTS];
  int unsigned       job_total;
  logic [TIME_W-1:0] sched_clock;

  sched_result_t pending_results [$];
  int unsigned   error_count = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   items_sent = 0;
  int unsigned   rx_hold_cycles = 0;
  bit            tx_steady = 1'b0;
  bit            rx_steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic sched_result_t schedule_step(input logic [OP_W-1:0] op,
                                                  input logic [ARR_W-1:0] at,
                                                  input logic [BT_W-1:0] bt);
    sched_result_t     res;
    bit                found;
    int unsigned       i;
    int unsigned       best;
    logic [BT_W-1:0]   best_left;
    logic [TIME_W-1:0] turnaround;
    res = '0;
    found = 1'b0;
    best = 0;
    best_left = '0;
    case (op)
      OP_LOAD: begin
        if (job_total < JOB_SLOTS) begin
          job_arrival[job_total] = at;
          job_burst[job_total] = bt;
          job_remaining[job_total] = bt;
          res.slot = SLOT_W'(job_total);
          job_total++;
        end else begin
          res.status = 1'b1;
        end
      end
      OP_TICK: begin
        for (i = 0; i < job_total; i++) begin
          if (TIME_W'(job_arrival[i]) <= sched_clock && job_remaining[i] != '0 &&
              (!found || job_remaining[i] < best_left)) begin
            found = 1'b1;
            best = i;
            best_left = job_remaining[i];
          end
        end
        if (sched_clock != TIME_MAX) sched_clock++;
        if (!found) begin
          res.idle = 1'b1;
        end else begin
          job_remaining[best] = best_left - 1'b1;
          res.slot = SLOT_W'(best);
          if (job_remaining[best] == '0) begin
            turnaround = (sched_clock >= TIME_W'(job_arrival[best])) ?
                         sched_clock - TIME_W'(job_arrival[best]) : '0;
            res.finished = 1'b1;
            res.completion_time = sched_clock;
            res.turnaround_time = turnaround;
            res.waiting_time = (turnaround >= TIME_W'(job_burst[best])) ?
                               turnaround - TIME_W'(job_burst[best]) : '0;
          end
        end
      end
      OP_CLEAR: begin
        job_total = 0;
        sched_clock = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    sched_result_t want;
    bit            moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        pending_results.insert(pending_results.size(),
                               schedule_step(in_ch.operation, in_ch.arrival_time,
                                             in_ch.burst_time));
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          error_count++;
          $error("result transfer with no expected result, slot %0d", out_ch.slot);
        end else begin
          want = pending_results.pop_front();
          check_field("slot", want.slot, out_ch.slot);
          check_field("status", want.status, out_ch.status);
          check_field("idle", want.idle, out_ch.idle);
          check_field("finished", want.finished, out_ch.finished);
          check_field("completion_time", want.completion_time, out_ch.completion_time);
          check_field("turnaround_time", want.turnaround_time, out_ch.turnaround_time);
          check_field("waiting_time", want.waiting_time, out_ch.waiting_time);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (rst_n === 1'b1);
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : result_receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles != 0) begin
        stall_left = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else if (stall_left == 0 && !rx_steady && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ARR_W-1:0] at,
                           input logic [BT_W-1:0] bt);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.arrival_time = at;
    in_ch.burst_time = bt;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [ARR_W-1:0] pick_arrival(input logic [TIME_W-1:0] now);
    if ($urandom_range(0, 99) < 88) return ARR_W'(now + $urandom_range(0, 5));
    return ARR_W'($urandom);
  endfunction

  function automatic logic [BT_W-1:0] pick_burst();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 90) return BT_W'($urandom_range(1, 6));
    return BT_W'($urandom);
  endfunction

  // Ties, a job that never becomes eligible, the unused code and both field extremes.
  task automatic test_special_cases();
    send_item(OP_CLEAR, ARR_W'($urandom), BT_W'($urandom));
    send_item(OP_TICK, 16'hFFFF, 16'hFFFF);
    send_item(OP_LOAD, 16'h0000, 16'd2);
    send_item(OP_LOAD, 16'h0000, 16'd2);
    send_item(OP_LOAD, 16'h0000, 16'h0000);
    send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    send_item(OP_LOAD, 16'hFFFF, 16'hFFFF);
    repeat (5) send_item(OP_TICK, ARR_W'($urandom), BT_W'($urandom));
  endtask

  task automatic test_table_full();
    int unsigned k;
    for (k = 0; k < 14; k++) begin
      send_item(OP_LOAD, ARR_W'($urandom_range(0, 12)), BT_W'($urandom));
    end
    send_item(OP_TICK, ARR_W'($urandom), BT_W'($urandom));
  endtask

  task automatic test_random_schedules(input int unsigned item_goal);
    int unsigned       first_item;
    int unsigned       jobs;
    int unsigned       ticks;
    int unsigned       k;
    int unsigned       roll;
    logic [TIME_W-1:0] clock_guess;
    logic [BT_W-1:0]   bt;
    first_item = items_sent;
    clock_guess = '0;
    while (items_sent - first_item < item_goal) begin
      if ($urandom_range(0, 99) < 85) begin
        send_item(OP_CLEAR, ARR_W'($urandom), BT_W'($urandom));
        clock_guess = '0;
      end
      jobs = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 8);
      ticks = 6;
      for (k = 0; k < jobs; k++) begin
        bt = pick_burst();
        send_item(OP_LOAD, pick_arrival(clock_guess), bt);
        if (bt < 16) ticks += bt;
      end
      for (k = 0; k < ticks; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          send_item(OP_LOAD, pick_arrival(clock_guess), pick_burst());
        end else if (roll < 11) begin
          send_item(OP_UNUSED, ARR_W'($urandom), BT_W'($urandom));
        end else if (roll < 12) begin
          send_item(OP_CLEAR, ARR_W'($urandom), BT_W'($urandom));
          clock_guess = '0;
        end else begin
          send_item(OP_TICK, ARR_W'($urandom), BT_W'($urandom));
          clock_guess++;
        end
      end
    end
  endtask

  // The receiver stops for a long stretch so that the block backs up onto its input.
  task automatic test_receiver_hold();
    int unsigned k;
    send_item(OP_CLEAR, ARR_W'($urandom), BT_W'($urandom));
    rx_hold_cycles = 300;
    for (k = 0; k < 8; k++) begin
      send_item(OP_LOAD, ARR_W'(k), BT_W'($urandom_range(1, 4)));
    end
    repeat (12) send_item(OP_TICK, ARR_W'($urandom), BT_W'($urandom));
  endtask

  task automatic test_drain_and_steady_stream();
    pause_until_drained();
    send_item(OP_CLEAR, ARR_W'($urandom), BT_W'($urandom));
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    test_random_schedules(60);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    int unsigned n;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_LOAD;
    in_ch.arrival_time = '0;
    in_ch.burst_time = '0;
    for (n = 0; n < JOB_SLOTS; n++) begin
      job_arrival[n] = '0;
      job_burst[n] = '0;
      job_remaining[n] = '0;
    end
    job_total = 0;
    sched_clock = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_special_cases();
    test_table_full();
    test_random_schedules(380);
    test_receiver_hold();
    test_drain_and_steady_stream();

    pause_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/srt_pkg.sv
rtl/srt_if.sv
rtl/srt_ram.sv
rtl/srt_ctrl.sv
rtl/srt_dp.sv
rtl/shortest_remaining_time_scheduler.sv
tb/sv/tb_shortest_remaining_time_scheduler.sv
